// File: sv/wpf_pkg.sv
// shared types and constants of the waypoint heading follower
package wpf_pkg;

    // path storage
    localparam int PATH_DEPTH = 64;
    localparam int PTR_W      = $clog2(PATH_DEPTH);
    localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // field widths
    localparam int POS_W   = 32;
    localparam int ANG_W   = 15;
    localparam int SPEED_W = 16;
    localparam int TOL_W   = 14;
    localparam int TURN_W  = 15;
    localparam int REACH_W = 24;
    localparam int MAG_W   = 31;
    localparam int ERR_W   = 18;

    // one stored waypoint: x, y, heading
    localparam int WP_W = 2 * POS_W + ANG_W;

    // angles in Q3.12
    localparam logic signed [ERR_W-1:0] PI_Q12     = 18'sd12868;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 18'sd25736;

    // register reset values
    localparam logic [REACH_W-1:0] REACH_RST    = 24'd13107;
    localparam logic [TOL_W-1:0]   TOL_RST      = 14'd41;
    localparam logic [SPEED_W-1:0] CRUISE_RST   = 16'd154;
    localparam logic [SPEED_W-1:0] STRAIGHT_RST = 16'd256;
    localparam logic [TURN_W-1:0]  TURN_RST     = 15'd307;

    // request kinds
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_POSE   = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REACH    = 3'd0,
        CFG_TOL      = 3'd1,
        CFG_CRUISE   = 3'd2,
        CFG_STRAIGHT = 3'd3,
        CFG_TURN     = 3'd4
    } t_cfg_idx;

    // tick sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SQR,
        ST_CMP,
        ST_EMPTY
    } t_state;

endpackage

// File: sv/wpf_in_if.sv
// request channel: kind, position and angle words
interface wpf_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [14:0]       angle;

    modport source (output valid, req_type, pos_x, pos_y, angle, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, angle, output ready);
endinterface

// File: sv/wpf_out_if.sv
// command channel: speed words toward the drive
interface wpf_out_if;
    logic                     valid;
    logic                     ready;
    logic [15:0]              linear_speed;
    logic signed [15:0]       angular_speed;
    logic                     path_done;

    modport source (output valid, linear_speed, angular_speed, path_done, input ready);
    modport sink   (input valid, linear_speed, angular_speed, path_done, output ready);
endinterface

// File: sv/wpf_ram.sv
// generic single write port ram with registered read
module wpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/waypoint_heading_follower_core.sv
// top level of the waypoint heading follower
// Waypoint heading follower. Clear, append and pose words are taken in the idle
// state. A control tick runs through a small sequencer around one shared 31 x 31
// squaring multiplier: squared x offset, squared y offset, squared reach distance,
// then the compare and heading check. A tick that reaches its waypoint advances
// the head and publishes no command; else the compare step registers its command.
// A tick before both a path and a pose publishes no command. A tick that finds
// the path empty registers a zero command with path done set in the empty step.
// The request side is not ready while a tick is in the sequencer. A finished
// command waits in the output register, and a tick that wants to publish waits
// in the compare or empty step only while that register is occupied and not taken.
// Waypoints live in a 64 entry ram read at the head by each tick entering ST_DIFF.
module waypoint_heading_follower_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wpf_in_if.sink                             i_req,
    wpf_out_if.source                          o_cmd,
    input  logic                               i_cfg_we,
    input  logic [wpf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wpf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // saturated magnitude of a coordinate difference
    function automatic logic [wpf_pkg::MAG_W-1:0] sat_mag(
        input logic signed [wpf_pkg::POS_W-1:0] a,
        input logic signed [wpf_pkg::POS_W-1:0] b
    );
        logic signed [wpf_pkg::POS_W:0] d;
        logic [wpf_pkg::POS_W:0]        m;
        d = {a[wpf_pkg::POS_W-1], a} - {b[wpf_pkg::POS_W-1], b};
        m = d[wpf_pkg::POS_W] ? (wpf_pkg::POS_W+1)'(-d) : (wpf_pkg::POS_W+1)'(d);
        if (m > (wpf_pkg::POS_W+1)'({wpf_pkg::MAG_W{1'b1}})) begin
            return {wpf_pkg::MAG_W{1'b1}};
        end
        return m[wpf_pkg::MAG_W-1:0];
    endfunction

    // configuration registers
    logic [wpf_pkg::REACH_W-1:0] r_reach;
    logic [wpf_pkg::TOL_W-1:0]   r_tol;
    logic [wpf_pkg::SPEED_W-1:0] r_cruise;
    logic [wpf_pkg::SPEED_W-1:0] r_straight;
    logic [wpf_pkg::TURN_W-1:0]  r_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach    <= wpf_pkg::REACH_RST;
            r_tol      <= wpf_pkg::TOL_RST;
            r_cruise   <= wpf_pkg::CRUISE_RST;
            r_straight <= wpf_pkg::STRAIGHT_RST;
            r_turn     <= wpf_pkg::TURN_RST;
        end else if (i_cfg_we) begin
            case (wpf_pkg::t_cfg_idx'(i_cfg_idx))
                wpf_pkg::CFG_REACH:    r_reach    <= i_cfg_data[wpf_pkg::REACH_W-1:0];
                wpf_pkg::CFG_TOL:      r_tol      <= i_cfg_data[wpf_pkg::TOL_W-1:0];
                wpf_pkg::CFG_CRUISE:   r_cruise   <= i_cfg_data[wpf_pkg::SPEED_W-1:0];
                wpf_pkg::CFG_STRAIGHT: r_straight <= i_cfg_data[wpf_pkg::SPEED_W-1:0];
                wpf_pkg::CFG_TURN:     r_turn     <= i_cfg_data[wpf_pkg::TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    wpf_pkg::t_state             r_state, n_state;
    logic [wpf_pkg::PTR_W-1:0]   r_head, n_head;
    logic [wpf_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_path_seen, n_path_seen;
    logic                        r_pose_seen, n_pose_seen;
    logic                        r_ovalid, n_ovalid;

    // payload state
    logic signed [wpf_pkg::POS_W-1:0] r_pose_x, n_pose_x;
    logic signed [wpf_pkg::POS_W-1:0] r_pose_y, n_pose_y;
    logic signed [wpf_pkg::ANG_W-1:0] r_pose_yaw, n_pose_yaw;
    logic [wpf_pkg::MAG_W-1:0]        r_mop, n_mop;
    logic [2*wpf_pkg::MAG_W-1:0]      r_prod, n_prod;
    logic [2*wpf_pkg::MAG_W:0]        r_acc, n_acc;
    logic [wpf_pkg::SPEED_W-1:0]      r_lin, n_lin;
    logic [wpf_pkg::SPEED_W-1:0]      r_ang, n_ang;
    logic                             r_done, n_done;

    // waypoint ram signals
    logic                        w_we, w_re;
    logic [wpf_pkg::PTR_W-1:0]   w_waddr;
    logic [wpf_pkg::WP_W-1:0]    w_wdata, w_rdata;
    logic [wpf_pkg::CNT_W:0]     w_slot_sum;

    // fields of the head waypoint
    logic signed [wpf_pkg::POS_W-1:0] w_wp_x, w_wp_y;
    logic signed [wpf_pkg::ANG_W-1:0] w_wp_h;

    // shared squaring unit
    logic [2*wpf_pkg::MAG_W-1:0] w_square;

    // heading error
    logic signed [wpf_pkg::ERR_W-1:0] w_err_raw, w_err_a, w_err;
    logic [wpf_pkg::ERR_W-1:0]        w_err_mag;
    logic signed [wpf_pkg::ERR_W-1:0] w_tol_s;

    logic w_accept, w_slot_free;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_ovalid || o_cmd.ready;

    assign {w_wp_x, w_wp_y, w_wp_h} = w_rdata;

    assign w_square = r_mop * r_mop;

    // tail slot for an append
    assign w_slot_sum = (wpf_pkg::CNT_W+1)'(r_head) + (wpf_pkg::CNT_W+1)'(r_count);
    assign w_waddr    = (w_slot_sum >= (wpf_pkg::CNT_W+1)'(wpf_pkg::PATH_DEPTH))
                      ? wpf_pkg::PTR_W'(w_slot_sum - (wpf_pkg::CNT_W+1)'(wpf_pkg::PATH_DEPTH))
                      : wpf_pkg::PTR_W'(w_slot_sum);
    assign w_wdata    = {i_req.pos_x, i_req.pos_y, i_req.angle};
    assign w_we       = w_accept && (wpf_pkg::t_req'(i_req.req_type) == wpf_pkg::REQ_APPEND)
                      && (r_count < wpf_pkg::CNT_W'(wpf_pkg::PATH_DEPTH));
    assign w_re       = w_accept && (wpf_pkg::t_req'(i_req.req_type) == wpf_pkg::REQ_TICK)
                      && r_path_seen && r_pose_seen && (r_count != '0);

    wpf_ram #(
        .WIDTH (wpf_pkg::WP_W),
        .DEPTH (wpf_pkg::PATH_DEPTH)
    ) u_wp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // heading error wrapped once each way
    always_comb begin
        w_err_raw = wpf_pkg::ERR_W'(r_pose_yaw) - wpf_pkg::ERR_W'(w_wp_h);
        w_err_a   = (w_err_raw > wpf_pkg::PI_Q12) ? w_err_raw - wpf_pkg::TWO_PI_Q12
                                                  : w_err_raw;
        w_err     = (w_err_a < -wpf_pkg::PI_Q12) ? w_err_a + wpf_pkg::TWO_PI_Q12
                                                 : w_err_a;
        w_err_mag = w_err[wpf_pkg::ERR_W-1] ? wpf_pkg::ERR_W'(-w_err)
                                            : wpf_pkg::ERR_W'(w_err);
        w_tol_s   = $signed(wpf_pkg::ERR_W'(r_tol));
    end

    assign i_req.ready = (r_state == wpf_pkg::ST_IDLE);

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_path_seen = r_path_seen;
        n_pose_seen = r_pose_seen;
        n_ovalid    = r_ovalid && !o_cmd.ready;
        n_pose_x    = r_pose_x;
        n_pose_y    = r_pose_y;
        n_pose_yaw  = r_pose_yaw;
        n_mop       = r_mop;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_lin       = r_lin;
        n_ang       = r_ang;
        n_done      = r_done;

        case (r_state)
            wpf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (wpf_pkg::t_req'(i_req.req_type))
                        wpf_pkg::REQ_CLEAR: begin
                            n_head      = '0;
                            n_count     = '0;
                            n_path_seen = 1'b1;
                        end
                        wpf_pkg::REQ_APPEND: begin
                            if (w_we) begin
                                n_count = r_count + 1'b1;
                            end
                            n_path_seen = 1'b1;
                        end
                        wpf_pkg::REQ_POSE: begin
                            n_pose_x    = i_req.pos_x;
                            n_pose_y    = i_req.pos_y;
                            n_pose_yaw  = i_req.angle;
                            n_pose_seen = 1'b1;
                        end
                        wpf_pkg::REQ_TICK: begin
                            if (r_path_seen && r_pose_seen) begin
                                n_state = (r_count == '0) ? wpf_pkg::ST_EMPTY
                                                          : wpf_pkg::ST_DIFF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // x offset magnitude from the head waypoint
            wpf_pkg::ST_DIFF: begin
                n_mop   = sat_mag(r_pose_x, w_wp_x);
                n_state = wpf_pkg::ST_SQX;
            end
            // square x, load y offset
            wpf_pkg::ST_SQX: begin
                n_prod  = w_square;
                n_mop   = sat_mag(r_pose_y, w_wp_y);
                n_state = wpf_pkg::ST_SQY;
            end
            // square y, keep x squared, load reach
            wpf_pkg::ST_SQY: begin
                n_acc   = (2*wpf_pkg::MAG_W+1)'(r_prod);
                n_prod  = w_square;
                n_mop   = wpf_pkg::MAG_W'(r_reach);
                n_state = wpf_pkg::ST_SQR;
            end
            // square reach, sum distance terms
            wpf_pkg::ST_SQR: begin
                n_acc   = r_acc + (2*wpf_pkg::MAG_W+1)'(r_prod);
                n_prod  = w_square;
                n_state = wpf_pkg::ST_CMP;
            end
            // reach check: advance past a reached waypoint, else heading command
            wpf_pkg::ST_CMP: begin
                if (r_acc <= (2*wpf_pkg::MAG_W+1)'(r_prod)) begin
                    n_head  = (r_head == wpf_pkg::PTR_W'(wpf_pkg::PATH_DEPTH - 1))
                            ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = wpf_pkg::ST_IDLE;
                end else if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_done   = 1'b0;
                    if (w_err_mag > wpf_pkg::ERR_W'(r_tol)) begin
                        n_lin = r_cruise;
                        n_ang = (w_err > w_tol_s)
                              ? wpf_pkg::SPEED_W'(0) - wpf_pkg::SPEED_W'(r_turn)
                              : wpf_pkg::SPEED_W'(r_turn);
                    end else begin
                        n_lin = r_straight;
                        n_ang = '0;
                    end
                    n_state = wpf_pkg::ST_IDLE;
                end
            end
            // zero command for an empty path
            wpf_pkg::ST_EMPTY: begin
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_lin    = '0;
                    n_ang    = '0;
                    n_done   = 1'b1;
                    n_state  = wpf_pkg::ST_IDLE;
                end
            end
            default: n_state = wpf_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wpf_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_path_seen <= 1'b0;
            r_pose_seen <= 1'b0;
            r_ovalid    <= 1'b0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_pose_yaw  <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_path_seen <= n_path_seen;
            r_pose_seen <= n_pose_seen;
            r_ovalid    <= n_ovalid;
            r_pose_x    <= n_pose_x;
            r_pose_y    <= n_pose_y;
            r_pose_yaw  <= n_pose_yaw;
        end
    end

    // datapath and command word registers
    always_ff @(posedge i_clk) begin
        r_mop  <= n_mop;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_lin  <= n_lin;
        r_ang  <= n_ang;
        r_done <= n_done;
    end

    // command word out
    assign o_cmd.valid         = r_ovalid;
    assign o_cmd.linear_speed  = r_lin;
    assign o_cmd.angular_speed = $signed(r_ang);
    assign o_cmd.path_done     = r_done;

endmodule
